// ===== hw/rtl/sfp_pkg.sv =====
// Shared types and constants of the sync frame parser.
`timescale 1ns / 1ps

package sfp_pkg;

  // Largest payload length that a frame may announce.
  localparam int unsigned SFP_MAX_PAYLOAD = 4096;

  localparam int unsigned SFP_CFG_IDX_W = 2;

  // Configuration register indexes.
  localparam logic [SFP_CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
  localparam logic [SFP_CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
  localparam logic [SFP_CFG_IDX_W-1:0] CFG_END_MARKER  = 2'd2;

  localparam logic [7:0] CFG_SYNC_FIRST_RST  = 8'd255;
  localparam logic [7:0] CFG_SYNC_SECOND_RST = 8'd90;
  localparam logic [7:0] CFG_END_MARKER_RST  = 8'd51;

  typedef enum logic [2:0] {
    EV_NONE      = 3'd0,
    EV_PAYLOAD   = 3'd1,
    EV_ACCEPT    = 3'd2,
    EV_CRC_BAD   = 3'd3,
    EV_END_BAD   = 3'd4,
    EV_TOO_LONG  = 3'd5
  } sfp_event_t;

  typedef struct packed {
    logic [7:0] sync_first;
    logic [7:0] sync_second;
    logic [7:0] end_marker;
  } sfp_cfg_t;

  typedef struct packed {
    logic [7:0] byte_in;
  } sfp_in_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [7:0]  payload_byte;
    logic [11:0] payload_index;
    logic [7:0]  msg_id;
    logic [7:0]  msg_class;
    logic [15:0] msg_length;
    logic [15:0] frame_crc;
  } sfp_out_t;

endpackage

// ===== hw/rtl/sfp_stream_if.sv =====
// Valid/ready stream interface carrying one word per handshake.
`timescale 1ns / 1ps

interface sfp_stream_if #(
  parameter type payload_t = logic [7:0]
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/sfp_core.sv =====
// Frame parsing state machine with running CRC-16 and frame field registers.
`timescale 1ns / 1ps

module sfp_core
  import sfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = SFP_MAX_PAYLOAD
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       step_en,
  input  logic [7:0] byte_in,
  input  sfp_cfg_t   cfg,
  output sfp_out_t   res
);

  typedef enum logic [3:0] {
    PH_HUNT    = 4'd0,
    PH_SYNC2   = 4'd1,
    PH_ID      = 4'd2,
    PH_CLASS   = 4'd3,
    PH_LEN_HI  = 4'd4,
    PH_LEN_LO  = 4'd5,
    PH_PAYLOAD = 4'd6,
    PH_CRC_HI  = 4'd7,
    PH_CRC_LO  = 4'd8,
    PH_END     = 4'd9
  } phase_t;

  localparam logic [15:0] CRC_POLY = 16'h8408;
  localparam logic [15:0] MAX_LEN  = 16'(MAX_PAYLOAD);

  // Reflected CRC-16 update over one byte, LSB first.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  phase_t      phase_r, phase_nxt;
  logic [15:0] count_r, count_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [15:0] rcrc_r, rcrc_nxt;
  logic [15:0] len_r, len_nxt;
  logic [7:0]  id_r, id_nxt;
  logic [7:0]  class_r, class_nxt;
  sfp_event_t  ev;
  logic [7:0]  pbyte;
  logic [11:0] pidx;

  always_comb begin
    phase_nxt = phase_r;
    count_nxt = count_r;
    crc_nxt   = crc_r;
    rcrc_nxt  = rcrc_r;
    len_nxt   = len_r;
    id_nxt    = id_r;
    class_nxt = class_r;
    ev        = EV_NONE;
    pbyte     = 8'h00;
    pidx      = 12'h000;
    unique case (phase_r)
      PH_SYNC2: begin
        if (byte_in == cfg.sync_second) phase_nxt = PH_ID;
      end
      PH_ID: begin
        id_nxt    = byte_in;
        crc_nxt   = crc_byte(16'h0000, byte_in);
        phase_nxt = PH_CLASS;
      end
      PH_CLASS: begin
        class_nxt = byte_in;
        crc_nxt   = crc_byte(crc_r, byte_in);
        phase_nxt = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        len_nxt   = {byte_in, 8'h00};
        crc_nxt   = crc_byte(crc_r, byte_in);
        phase_nxt = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        len_nxt   = {len_r[15:8], byte_in};
        crc_nxt   = crc_byte(crc_r, byte_in);
        count_nxt = 16'h0000;
        if (len_nxt > MAX_LEN) begin
          ev        = EV_TOO_LONG;
          phase_nxt = PH_HUNT;
        end else if (len_nxt == 16'h0000) begin
          phase_nxt = PH_CRC_HI;
        end else begin
          phase_nxt = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        ev        = EV_PAYLOAD;
        pbyte     = byte_in;
        pidx      = count_r[11:0];
        crc_nxt   = crc_byte(crc_r, byte_in);
        count_nxt = count_r + 16'd1;
        if (count_nxt >= len_r) phase_nxt = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        rcrc_nxt  = {byte_in, 8'h00};
        phase_nxt = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        rcrc_nxt = {rcrc_r[15:8], byte_in};
        if (rcrc_nxt != crc_r) begin
          ev        = EV_CRC_BAD;
          phase_nxt = PH_HUNT;
        end else begin
          phase_nxt = PH_END;
        end
      end
      PH_END: begin
        ev        = (byte_in == cfg.end_marker) ? EV_ACCEPT : EV_END_BAD;
        phase_nxt = PH_HUNT;
      end
      default: begin
        // Hunting, and any phase code that means nothing.
        phase_nxt = PH_HUNT;
        if (byte_in == cfg.sync_first) begin
          phase_nxt = PH_SYNC2;
          count_nxt = 16'h0000;
        end
      end
    endcase
  end

  assign res.event_res     = ev;
  assign res.payload_byte  = pbyte;
  assign res.payload_index = pidx;
  assign res.msg_id        = id_nxt;
  assign res.msg_class     = class_nxt;
  assign res.msg_length    = len_nxt;
  assign res.frame_crc     = rcrc_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      count_r <= 16'h0000;
      crc_r   <= 16'h0000;
      rcrc_r  <= 16'h0000;
      len_r   <= 16'h0000;
      id_r    <= 8'h00;
      class_r <= 8'h00;
    end else if (step_en) begin
      phase_r <= phase_nxt;
      count_r <= count_nxt;
      crc_r   <= crc_nxt;
      rcrc_r  <= rcrc_nxt;
      len_r   <= len_nxt;
      id_r    <= id_nxt;
      class_r <= class_nxt;
    end
  end

`ifndef SYNTHESIS
  // The payload phase is only ever left once the count reaches the length.
  a_count_below_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> count_r < len_r)
    else $error("payload count reached frame length inside payload phase");

  // A matching CRC always leads to the end marker check.
  a_crc_ok_to_end: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && phase_r == PH_CRC_LO && ev == EV_NONE |=> phase_r == PH_END)
    else $error("good CRC did not move to end marker check");

  // No event is raised while still looking for sync.
  a_quiet_in_sync: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && (phase_r == PH_HUNT || phase_r == PH_SYNC2) |-> ev == EV_NONE)
    else $error("event raised during sync hunt");
`endif

endmodule

// ===== hw/rtl/sync_frame_parser_crc16.sv =====
// Top level of the sync frame parser: handshake, configuration and result registers.
`timescale 1ns / 1ps

// Byte-stream frame parser. Every byte word taken on the input channel yields
// exactly one result word, in order. The block takes one byte per clock cycle
// while its result words are read; each byte passes through the input
// register, then the result register, and the byte-wide CRC-16 update together
// with the phase step is the one combinational path between them. Frames are
// two sync bytes, id, class, a big-endian 16-bit length, the payload, the CRC
// high and low bytes and an end marker; the CRC (reflected, poly 0x8408,
// init 0) covers id, class, length and payload. Events report payload bytes,
// accepted frames, CRC mismatches, bad end markers and oversize lengths. The
// sync and end marker values are written through the cfg_ port; write them
// only while no byte is in flight. While a result word is stalled, the input
// register can still take one more byte, and after that the input stays
// stalled until the result word is read.
module sync_frame_parser_crc16
  import sfp_pkg::*;
#(
  parameter int unsigned MAX_PAYLOAD = SFP_MAX_PAYLOAD
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  sfp_stream_if.sink               in_s,
  sfp_stream_if.source             out_s,
  input  logic                     cfg_we,
  input  logic [SFP_CFG_IDX_W-1:0] cfg_idx,
  input  logic [7:0]               cfg_wdata
);

  sfp_cfg_t   cfg_r;
  logic       s1_vld_r;
  logic [7:0] s1_byte_r;
  logic       out_vld_r;
  sfp_out_t   out_data_r;
  sfp_out_t   step_res;
  logic       s1_adv;
  logic       in_acc;

  // The input word moves on when the result register is empty or being read.
  assign s1_adv     = s1_vld_r && (!out_vld_r || out_s.ready);
  assign in_s.ready = !s1_vld_r || s1_adv;
  assign in_acc     = in_s.valid && in_s.ready;

  assign out_s.valid   = out_vld_r;
  assign out_s.payload = out_data_r;

  sfp_core #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .step_en (s1_adv),
    .byte_in (s1_byte_r),
    .cfg     (cfg_r),
    .res     (step_res)
  );

  // Control state and configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r          <= 1'b0;
      out_vld_r         <= 1'b0;
      cfg_r.sync_first  <= CFG_SYNC_FIRST_RST;
      cfg_r.sync_second <= CFG_SYNC_SECOND_RST;
      cfg_r.end_marker  <= CFG_END_MARKER_RST;
    end else begin
      if (in_acc) begin
        s1_vld_r <= 1'b1;
      end else if (s1_adv) begin
        s1_vld_r <= 1'b0;
      end
      if (s1_adv) begin
        out_vld_r <= 1'b1;
      end else if (out_s.ready) begin
        out_vld_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_idx)
          CFG_SYNC_FIRST:  cfg_r.sync_first  <= cfg_wdata;
          CFG_SYNC_SECOND: cfg_r.sync_second <= cfg_wdata;
          CFG_END_MARKER:  cfg_r.end_marker  <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    if (in_acc) s1_byte_r <= in_s.payload.byte_in;
    if (s1_adv) out_data_r <= step_res;
  end

`ifndef SYNTHESIS
  // A word leaving the input register always lands in the result register.
  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv |=> out_vld_r)
    else $error("advanced word did not reach result register");

  // A result word that is not read stays offered.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_s.ready |=> out_vld_r)
    else $error("result word dropped while stalled");

  // A stalled result word keeps its contents.
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r && !out_s.ready |=> $stable(out_data_r))
    else $error("result word changed while stalled");

  // An empty input register always takes a word.
  a_in_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_vld_r |-> in_s.ready)
    else $error("input not ready with empty input register");
`endif

endmodule

// ===== tb/sync_frame_parser_crc16_tb.sv =====
// Self-checking testbench of the sync frame parser with CRC-16 framing.
`timescale 1ns / 1ps

// The testbench drives byte words into the parser and predicts one result word
// per accepted byte with its own model of the frame parser. A single checker
// process compares every result word against the oldest prediction, field by
// field. The test tasks cover directed frames, mixed random traffic, several
// sync and end marker settings, a long payload and a final stretch with no
// idling on either side.
module sync_frame_parser_crc16_tb
  import sfp_pkg::*;
();

  localparam int unsigned CLK_HALF_NS  = 6;
  localparam int unsigned RESET_CYCLES = 12;
  // The timeout leaves ample margin on top of the slowest correct run.
  localparam longint unsigned TIMEOUT_NS = 64'd10_000_000;
  localparam int unsigned DRAIN_LIMIT  = 4000;
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned MAX_REPORTS  = 40;
  localparam int unsigned LONG_LEN     = 256;

  // Parse phases of the predictor, in the order a frame walks through them.
  typedef enum logic [3:0] {
    PH_HUNT, PH_SYNC2, PH_ID, PH_CLASS, PH_LEN_HI, PH_LEN_LO,
    PH_PAYLOAD, PH_CRC_HI, PH_CRC_LO, PH_END
  } parse_phase_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [SFP_CFG_IDX_W-1:0] cfg_idx;
  logic [7:0] cfg_wdata;

  sfp_stream_if #(.payload_t(sfp_in_t))  in_if ();
  sfp_stream_if #(.payload_t(sfp_out_t)) out_if ();

  sync_frame_parser_crc16 u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_s     (in_if),
    .out_s    (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the configuration and of the parser state.
  sfp_cfg_t     cfg_shadow;
  parse_phase_t prs_phase;
  logic [15:0]  prs_count;
  logic [15:0]  prs_crc;
  logic [15:0]  prs_rx_crc;
  logic [15:0]  prs_len;
  logic [7:0]   prs_id;
  logic [7:0]   prs_class;

  // Predicted result words, oldest first.
  sfp_out_t expected_results[$];

  int unsigned mismatch_count;
  int unsigned result_count;
  int unsigned sent_count;
  bit          gaps_on;
  bit          stalls_on;
  int unsigned stall_left;
  sfp_out_t    want_res;

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // Reflected CRC-16 update over one byte, least significant bit first.
  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ 16'h8408;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  // Advances the shadow parser by one byte and returns the result word that
  // the block must produce for it.
  function automatic sfp_out_t predict_parse_result(logic [7:0] b);
    sfp_out_t res;
    res = '0;
    res.event_res = EV_NONE;
    case (prs_phase)
      PH_SYNC2: begin
        // A wrong byte keeps the parser waiting; it never falls back to hunting.
        if (b == cfg_shadow.sync_second) prs_phase = PH_ID;
      end
      PH_ID: begin
        prs_id    = b;
        prs_crc   = crc16_update(16'h0000, b);
        prs_phase = PH_CLASS;
      end
      PH_CLASS: begin
        prs_class = b;
        prs_crc   = crc16_update(prs_crc, b);
        prs_phase = PH_LEN_HI;
      end
      PH_LEN_HI: begin
        prs_len   = {b, 8'h00};
        prs_crc   = crc16_update(prs_crc, b);
        prs_phase = PH_LEN_LO;
      end
      PH_LEN_LO: begin
        prs_len   = {prs_len[15:8], b};
        prs_crc   = crc16_update(prs_crc, b);
        prs_count = '0;
        if (prs_len > SFP_MAX_PAYLOAD) begin
          res.event_res = EV_TOO_LONG;
          prs_phase     = PH_HUNT;
        end else if (prs_len == 16'd0) begin
          prs_phase = PH_CRC_HI;
        end else begin
          prs_phase = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res.event_res     = EV_PAYLOAD;
        res.payload_byte  = b;
        res.payload_index = prs_count[11:0];
        prs_crc           = crc16_update(prs_crc, b);
        prs_count         = prs_count + 16'd1;
        if (prs_count >= prs_len) prs_phase = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        prs_rx_crc = {b, 8'h00};
        prs_phase  = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        prs_rx_crc = {prs_rx_crc[15:8], b};
        if (prs_rx_crc != prs_crc) begin
          res.event_res = EV_CRC_BAD;
          prs_phase     = PH_HUNT;
        end else begin
          prs_phase = PH_END;
        end
      end
      PH_END: begin
        res.event_res = (b == cfg_shadow.end_marker) ? EV_ACCEPT : EV_END_BAD;
        prs_phase     = PH_HUNT;
      end
      default: begin
        prs_phase = PH_HUNT;
        if (b == cfg_shadow.sync_first) begin
          prs_phase = PH_SYNC2;
          prs_count = '0;
        end
      end
    endcase
    res.msg_id     = prs_id;
    res.msg_class  = prs_class;
    res.msg_length = prs_len;
    res.frame_crc  = prs_rx_crc;
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    if (mismatch_count < MAX_REPORTS) $display("ERROR at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(string name, logic [15:0] got, logic [15:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d: %s is 0x%0h, expected 0x%0h",
                                result_count, name, got, want));
    end
  endtask

  // Every accepted result word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("result %0d arrived with no byte pending", result_count));
      end else begin
        want_res = expected_results.pop_front();
        check_field("event_res", 16'(out_if.payload.event_res), 16'(want_res.event_res));
        check_field("payload_byte", 16'(out_if.payload.payload_byte),
                    16'(want_res.payload_byte));
        check_field("payload_index", 16'(out_if.payload.payload_index),
                    16'(want_res.payload_index));
        check_field("msg_id", 16'(out_if.payload.msg_id), 16'(want_res.msg_id));
        check_field("msg_class", 16'(out_if.payload.msg_class), 16'(want_res.msg_class));
        check_field("msg_length", out_if.payload.msg_length, want_res.msg_length);
        check_field("frame_crc", out_if.payload.frame_crc, want_res.frame_crc);
      end
      result_count++;
    end
  end

  // The result side stalls in random bursts while stalls are enabled, and
  // otherwise always takes the next word.
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
    end else if (stalls_on && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 6);
    end
    out_if.ready <= (stall_left == 0);
  end

  // Sends one byte word. It is entered and left at a falling edge; valid stays
  // high across back-to-back words, and a gap lowers it for a short burst.
  task automatic send_byte(logic [7:0] b);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    in_if.valid          <= 1'b1;
    in_if.payload.byte_in <= b;
    do @(posedge clk); while (!in_if.ready);
    expected_results.push_back(predict_parse_result(b));
    sent_count++;
    @(negedge clk);
  endtask

  // Stops the input and waits until every predicted result has arrived. The
  // extra cycles cover the two-stage pipeline before any register write.
  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (expected_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Writes all three registers on consecutive cycles while the block is idle.
  task automatic apply_config(logic [7:0] first_v, logic [7:0] second_v, logic [7:0] end_v);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_SYNC_FIRST;
    cfg_wdata <= first_v;
    @(negedge clk);
    cfg_idx   <= CFG_SYNC_SECOND;
    cfg_wdata <= second_v;
    @(negedge clk);
    cfg_idx   <= CFG_END_MARKER;
    cfg_wdata <= end_v;
    @(negedge clk);
    cfg_we <= 1'b0;
    cfg_shadow.sync_first  = first_v;
    cfg_shadow.sync_second = second_v;
    cfg_shadow.end_marker  = end_v;
  endtask

  // Sends one frame built from the current sync and end values. An oversize
  // length ends the frame right after the length bytes, since the parser
  // drops back to hunting there. A corrupted CRC still gets a trailing byte,
  // which the parser then sees while hunting.
  task automatic send_frame(logic [7:0] id, logic [7:0] cls, logic [15:0] len,
                            bit corrupt_crc, bit corrupt_end);
    logic [15:0] crc;
    logic [7:0]  pb;
    crc = crc16_update(16'h0000, id);
    crc = crc16_update(crc, cls);
    crc = crc16_update(crc, len[15:8]);
    crc = crc16_update(crc, len[7:0]);
    send_byte(cfg_shadow.sync_first);
    send_byte(cfg_shadow.sync_second);
    send_byte(id);
    send_byte(cls);
    send_byte(len[15:8]);
    send_byte(len[7:0]);
    if (len > SFP_MAX_PAYLOAD) return;
    for (int unsigned i = 0; i < len; i++) begin
      pb  = 8'($urandom);
      crc = crc16_update(crc, pb);
      send_byte(pb);
    end
    if (corrupt_crc) crc = crc ^ 16'($urandom_range(1, 65535));
    send_byte(crc[15:8]);
    send_byte(crc[7:0]);
    send_byte(corrupt_end ? (cfg_shadow.end_marker ^ 8'($urandom_range(1, 255)))
                          : cfg_shadow.end_marker);
  endtask

  task automatic send_noise(int unsigned n);
    for (int unsigned i = 0; i < n; i++) send_byte(8'($urandom));
  endtask

  // Mixed traffic: mostly well-formed frames with random content and small
  // payloads, plus bad CRCs, bad end markers, oversize lengths, noise and
  // frames whose second sync byte arrives late.
  task automatic run_frame_mix(int unsigned n_bytes);
    int unsigned start;
    int unsigned pick;
    logic [15:0] len;
    start = sent_count;
    while (sent_count - start < n_bytes) begin
      pick = $urandom_range(0, 19);
      len  = ($urandom_range(0, 4) != 0) ? 16'($urandom_range(0, 12))
                                         : 16'($urandom_range(13, 64));
      if (pick < 12) begin
        send_frame(8'($urandom), 8'($urandom), len, 1'b0, 1'b0);
      end else if (pick < 14) begin
        send_frame(8'($urandom), 8'($urandom), len, 1'b1, 1'b0);
      end else if (pick < 16) begin
        send_frame(8'($urandom), 8'($urandom), len, 1'b0, 1'b1);
      end else if (pick == 16) begin
        len = ($urandom_range(0, 1) != 0) ? 16'(SFP_MAX_PAYLOAD + 1)
                                          : 16'($urandom_range(SFP_MAX_PAYLOAD + 1, 65535));
        send_frame(8'($urandom), 8'($urandom), len, 1'b0, 1'b0);
      end else if (pick == 17) begin
        // First sync byte, then stray bytes before the frame proper. The
        // frame's own first sync byte is just one more stray byte here.
        send_byte(cfg_shadow.sync_first);
        send_noise($urandom_range(1, 4));
        send_frame(8'($urandom), 8'($urandom), len, 1'b0, 1'b0);
      end else begin
        send_noise($urandom_range(1, 6));
      end
    end
  endtask

  task automatic test_directed_frames();
    // A zero-length frame goes straight from the length to the CRC.
    send_frame(8'h00, 8'hFF, 16'd0, 1'b0, 1'b0);
    // While waiting for the second sync byte, other bytes keep it waiting;
    // the length 0xFFFF that follows is oversize.
    send_byte(cfg_shadow.sync_first);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(cfg_shadow.sync_second);
    send_byte(8'hFF);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'hFF);
    // One payload byte with a wrong end marker, then a length just over the
    // limit, whose id and class stay visible between frames.
    send_frame(8'hFF, 8'h00, 16'd1, 1'b0, 1'b1);
    send_frame(8'h5A, 8'hA5, 16'(SFP_MAX_PAYLOAD + 1), 1'b0, 1'b0);
    send_noise(3);
  endtask

  task automatic test_random_traffic();
    run_frame_mix(200);
    // The sender holds off here until every result has come back.
    wait_idle();
    run_frame_mix(200);
  endtask

  task automatic test_config_settings();
    wait_idle();
    apply_config(8'h00, 8'h00, 8'h00);
    run_frame_mix(60);
    wait_idle();
    apply_config(8'hFF, 8'hFF, 8'hFF);
    run_frame_mix(60);
    wait_idle();
    apply_config(8'h00, 8'hFF, 8'h00);
    run_frame_mix(60);
    wait_idle();
    apply_config(8'hFF, 8'h00, 8'hFF);
    run_frame_mix(60);
    wait_idle();
    apply_config(8'($urandom), 8'($urandom), 8'($urandom));
    run_frame_mix(60);
    wait_idle();
    apply_config(CFG_SYNC_FIRST_RST, CFG_SYNC_SECOND_RST, CFG_END_MARKER_RST);
  endtask

  // A long payload walks the payload index through its full eight-bit range.
  task automatic test_long_frame();
    send_frame(8'($urandom), 8'($urandom), 16'(LONG_LEN), 1'b0, 1'b0);
  endtask

  task automatic test_back_to_back();
    wait_idle();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    run_frame_mix(120);
  endtask

  initial begin
    int unsigned drain_cycles;
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_idx        = CFG_SYNC_FIRST;
    cfg_wdata      = 8'h00;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    mismatch_count = 0;
    result_count   = 0;
    sent_count     = 0;
    stall_left     = 0;
    gaps_on        = 1'b1;
    stalls_on      = 1'b1;
    cfg_shadow.sync_first  = CFG_SYNC_FIRST_RST;
    cfg_shadow.sync_second = CFG_SYNC_SECOND_RST;
    cfg_shadow.end_marker  = CFG_END_MARKER_RST;
    prs_phase  = PH_HUNT;
    prs_count  = '0;
    prs_crc    = '0;
    prs_rx_crc = '0;
    prs_len    = '0;
    prs_id     = '0;
    prs_class  = '0;

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_frames();
    test_random_traffic();
    test_config_settings();
    test_long_frame();
    test_back_to_back();

    // Let the pipeline empty out, then give any stray word time to show up.
    in_if.valid <= 1'b0;
    drain_cycles = 0;
    while (expected_results.size() != 0 && drain_cycles < DRAIN_LIMIT) begin
      @(negedge clk);
      drain_cycles++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    end
    if (mismatch_count == 0) begin
      $display("sync_frame_parser_crc16 test passed");
    end else begin
      $display("sync_frame_parser_crc16 test failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #(TIMEOUT_NS);
    $display("TIMEOUT after %0t ns", $time);
    $display("sync_frame_parser_crc16 test failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/sfp_pkg.sv
hw/rtl/sfp_stream_if.sv
hw/rtl/sfp_core.sv
hw/rtl/sync_frame_parser_crc16.sv
tb/sync_frame_parser_crc16_tb.sv
